FILE: rtl/core/mbd_pkg.sv
// Shared types, constants and the Morse code tables for the button decoder.
package mbd_pkg;

    localparam int PATTERN_MAX_DEF = 5;
    localparam int CODE_COUNT      = 36;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLES_PER_UNIT = 2'd0;
    localparam logic [1:0] CFG_MARK_RUN         = 2'd1;
    localparam logic [1:0] CFG_END_GAP          = 2'd2;
    localparam logic [1:0] CFG_MAX_UNITS        = 2'd3;

    localparam logic [3:0] SPU_RESET       = 4'd10;
    localparam logic [3:0] MARK_RUN_RESET  = 4'd5;
    localparam logic [2:0] END_GAP_RESET   = 3'd7;
    localparam logic [4:0] MAX_UNITS_RESET = 5'd19;

    localparam logic [6:0] SEG_BLANK = 7'h00;

    // symbol k of a code at bit k, dash = 1
    localparam logic [4:0] CODE_BITS [CODE_COUNT] = '{
        5'd2,  5'd1,  5'd5,  5'd1,  5'd0,  5'd4,  5'd3,  5'd0,  5'd0,
        5'd14, 5'd5,  5'd2,  5'd3,  5'd1,  5'd7,  5'd6,  5'd11, 5'd2,
        5'd0,  5'd1,  5'd4,  5'd8,  5'd6,  5'd9,  5'd13, 5'd3,  5'd30,
        5'd28, 5'd24, 5'd16, 5'd0,  5'd1,  5'd3,  5'd7,  5'd15, 5'd31};

    localparam logic [4:0] CODE_LEN [CODE_COUNT] = '{
        5'd2, 5'd4, 5'd4, 5'd3, 5'd1, 5'd4, 5'd3, 5'd4, 5'd2,
        5'd4, 5'd3, 5'd4, 5'd2, 5'd2, 5'd3, 5'd4, 5'd4, 5'd3,
        5'd3, 5'd1, 5'd3, 5'd4, 5'd3, 5'd4, 5'd4, 5'd4, 5'd5,
        5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5};

    localparam logic [6:0] SEG_CODE [CODE_COUNT] = '{
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h30,
        7'h1E, 7'h76, 7'h38, 7'h4F, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50,
        7'h6D, 7'h78, 7'h3E, 7'h1C, 7'h4F, 7'h76, 7'h6E, 7'h5B, 7'h06,
        7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F, 7'h3F};

    typedef struct packed {
        logic [6:0] segments;
        logic       matched;
        logic [5:0] char_index;
        logic [4:0] symbol_count;
        logic [4:0] units_used;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [5:0] index;
        logic [6:0] seg;
    } t_match;

    // pattern length plus n symbols, saturating at 31
    function automatic logic [4:0] len_add(input logic [4:0] len, input logic [1:0] n);
        logic [5:0] sum;
        sum = {1'b0, len} + {4'd0, n};
        len_add = sum[5] ? 5'd31 : sum[4:0];
    endfunction

endpackage

FILE: rtl/core/morse_button_decoder_core.sv
// Morse button decoder: sample in, one decoded character out per character end.
//
// Input channel: one button sample per beat (0 pressed, 1 released) on
// i_in_valid / o_in_ready. Samples seen while idle and released are dropped.
// Configuration channel: i_cfg_valid with a 2-bit register index and data;
// o_cfg_ready is always high, so a write lands on the beat it is offered.
// Output channel: one result beat on o_out_valid / i_out_ready for each
// character that ends, carrying the held segment code, match flag, index,
// symbol count and units used.
// Throughput is one sample per cycle while o_in_ready is high: a sample's
// whole update (unit counter, mark detection, pattern shift and table lookup)
// fits between the state registers and the result register. A result goes to
// the output register, or to the skid stage while the output register is held.
// The output register is backed by a skid stage; o_in_ready only falls when
// both hold a result the receiver has not taken, which needs the receiver to
// stall across two character ends.
// Reset (synchronous, active low) returns to idle, blank display, default
// registers, and empties both result stages.
module morse_button_decoder_core
    import mbd_pkg::*;
#(
    parameter int PatternMax = PATTERN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_button_level,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_segments,
    output logic       o_matched,
    output logic [5:0] o_char_index,
    output logic [4:0] o_symbol_count,
    output logic [4:0] o_units_used,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);

    logic [3:0] r_spu, r_mark_run;
    logic [2:0] r_end_gap;
    logic [4:0] r_max_units;

    logic                  r_collecting;
    logic [3:0]            r_sin, r_prun;
    logic                  r_mark;
    logic [4:0]            r_uc;
    logic [2:0]            r_srun;
    logic [1:0]            r_mru;
    logic [PatternMax-1:0] r_bits;
    logic [4:0]            r_len;
    logic [6:0]            r_display;

    logic [3:0]            n_sin, n_prun;
    logic                  n_mark;
    logic [4:0]            n_uc;
    logic [2:0]            n_srun;
    logic [1:0]            n_mru;
    logic [PatternMax-1:0] n_bits;
    logic [4:0]            n_len;

    logic [3:0]            b_sin, b_prun;
    logic                  b_mark;
    logic [4:0]            b_uc;
    logic [2:0]            b_srun;
    logic [1:0]            b_mru;
    logic [PatternMax-1:0] b_bits;
    logic [4:0]            b_len;

    logic       pressed, active, unit_end, done, in_fire;
    logic [2:0] mru_inc;
    t_match     match;
    t_result    new_res;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    n_out_valid, n_skid_valid;
    t_result n_out, n_skid;
    logic    out_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ~r_skid_valid;
    assign in_fire     = i_in_valid & o_in_ready;
    assign pressed     = ~i_button_level;
    assign active      = r_collecting | pressed;

    always_comb begin
        // a fresh character starts from cleared state
        b_sin  = r_collecting ? r_sin  : '0;
        b_prun = r_collecting ? r_prun : '0;
        b_mark = r_collecting ? r_mark : 1'b0;
        b_uc   = r_collecting ? r_uc   : '0;
        b_srun = r_collecting ? r_srun : '0;
        b_mru  = r_collecting ? r_mru  : '0;
        b_bits = r_collecting ? r_bits : '0;
        b_len  = r_collecting ? r_len  : '0;

        if (pressed) begin
            n_prun = (b_prun == 4'd15) ? 4'd15 : b_prun + 4'd1;
        end else begin
            n_prun = 4'd0;
        end
        n_mark   = b_mark | (n_prun >= r_mark_run);
        n_sin    = b_sin + 4'd1;
        unit_end = (n_sin == r_spu);
        n_uc     = b_uc;
        n_srun   = b_srun;
        n_mru    = b_mru;
        n_bits   = b_bits;
        n_len    = b_len;
        mru_inc  = {1'b0, b_mru} + 3'd1;
        done     = 1'b0;

        if (unit_end) begin
            n_uc = b_uc + 5'd1;
            if (n_mark) begin
                n_srun = 3'd0;
                if (mru_inc == 3'd3) begin
                    for (int j = 0; j < PatternMax; j++) begin
                        if (b_len == 5'(j)) begin
                            n_bits[j] = 1'b1;
                        end
                    end
                    n_len = len_add(b_len, 2'd1);
                    n_mru = 2'd0;
                end else begin
                    n_mru = mru_inc[1:0];
                end
            end else begin
                n_srun = (b_srun == 3'd7) ? 3'd7 : b_srun + 3'd1;
                n_len  = len_add(b_len, b_mru);
                n_mru  = 2'd0;
            end
            n_sin  = 4'd0;
            n_prun = 4'd0;
            n_mark = 1'b0;
            done   = (n_srun == r_end_gap) || (n_uc == r_max_units);
            if (done) begin
                // leftover marks close as dots
                n_len = len_add(n_len, n_mru);
                n_mru = 2'd0;
            end
        end
    end

    mbd_match #(
        .PatternMax(PatternMax)
    ) u_match (
        .i_len  (n_len),
        .i_bits (n_bits),
        .o_match(match)
    );

    always_comb begin
        new_res.segments     = match.hit ? match.seg : r_display;
        new_res.matched      = match.hit;
        new_res.char_index   = match.index;
        new_res.symbol_count = n_len;
        new_res.units_used   = n_uc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spu       <= SPU_RESET;
            r_mark_run  <= MARK_RUN_RESET;
            r_end_gap   <= END_GAP_RESET;
            r_max_units <= MAX_UNITS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAMPLES_PER_UNIT: r_spu       <= i_cfg_data[3:0];
                CFG_MARK_RUN:         r_mark_run  <= i_cfg_data[3:0];
                CFG_END_GAP:          r_end_gap   <= i_cfg_data[2:0];
                CFG_MAX_UNITS:        r_max_units <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_display    <= SEG_BLANK;
        end else if (in_fire && active) begin
            r_collecting <= ~done;
            if (done && match.hit) begin
                r_display <= match.seg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && active) begin
            r_sin  <= n_sin;
            r_prun <= n_prun;
            r_mark <= n_mark;
            r_uc   <= n_uc;
            r_srun <= n_srun;
            r_mru  <= n_mru;
            r_bits <= n_bits;
            r_len  <= n_len;
        end
    end

    // result register with skid stage behind it
    assign out_take = r_out_valid & i_out_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (in_fire && active && done) begin
            if (!r_out_valid || out_take) begin
                n_out       = new_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = new_res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_segments     = r_out.segments;
    assign o_matched      = r_out.matched;
    assign o_char_index   = r_out.char_index;
    assign o_symbol_count = r_out.symbol_count;
    assign o_units_used   = r_out.units_used;

endmodule

FILE: rtl/core/mbd_match.sv
// Looks a finished symbol pattern up in the letter and digit code table.
module mbd_match
    import mbd_pkg::*;
#(
    parameter int PatternMax = PATTERN_MAX_DEF
) (
    input  logic [4:0]            i_len,
    input  logic [PatternMax-1:0] i_bits,
    output t_match                o_match
);

    always_comb begin
        o_match = '0;
        // walk downwards so the lowest matching index wins
        for (int k = CODE_COUNT - 1; k >= 0; k--) begin
            if (i_len == CODE_LEN[k] && i_bits == PatternMax'(CODE_BITS[k])) begin
                o_match.hit   = 1'b1;
                o_match.index = 6'(k);
                o_match.seg   = SEG_CODE[k];
            end
        end
    end

endmodule

FILE: rtl/core/mbd_checker.sv
// Port-level assertions for the Morse button decoder, bound to the top level.
module mbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [6:0] o_segments,
    input logic       o_matched,
    input logic [5:0] o_char_index,
    input logic [4:0] o_symbol_count,
    input logic [4:0] o_units_used
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_segments)
            && $stable(o_matched) && $stable(o_char_index)
            && $stable(o_symbol_count) && $stable(o_units_used))
        else $error("result beat changed while stalled");

    // input back-pressure only comes from results waiting downstream
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_nomatch_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_matched |-> o_char_index == 6'd0)
        else $error("char index set without a match");

    a_match_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_matched |-> o_symbol_count != 5'd0
            && o_symbol_count <= 5'd5 && o_char_index <= 6'd35)
        else $error("matched character out of code range");

endmodule

bind morse_button_decoder_core mbd_checker u_mbd_checker (.*);
